@@ sv/disjoint_set_union_find_assert.svh @@
// Assertion macros for the union-find engine.
// Used by the top level only; no other dependencies.
`ifndef DISJOINT_SET_UNION_FIND_ASSERT_SVH
`define DISJOINT_SET_UNION_FIND_ASSERT_SVH

// Same-cycle implication under an active-low reset.
`define DSU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("union-find check failed");

// Next-cycle implication under an active-low reset.
`define DSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("union-find check failed");

`endif

@@ sv/dsu_pkg.sv @@
// Shared types and constants for the union-find engine.
// No dependencies.
`default_nettype none

package dsu_pkg;

    localparam int MAX_ELEMENTS = 256;
    localparam int ELEM_W       = 8;
    localparam int COUNT_W      = 9;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 24;
    localparam int M_TUSER_W    = 2;

    typedef logic [ELEM_W-1:0]  elem_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam logic ACT_FIND  = 1'b0;
    localparam logic ACT_UNION = 1'b1;

    localparam count_t COUNT_RESET = count_t'(MAX_ELEMENTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_COMP,
        ST_MERGE,
        ST_DONE
    } walk_state_t;

    typedef struct packed {
        elem_t rd_addr;
        logic  wr_en;
        elem_t wr_addr;
        elem_t wr_data;
    } mem_req_t;

    typedef struct packed {
        elem_t  root;
        logic   merged;
        count_t set_count;
        logic   index_error;
    } dsu_res_t;

endpackage

`default_nettype wire

@@ sv/disjoint_set_union_find.sv @@
// Union-find engine with path compression over a 256-entry parent table.
// A find walks from elem_a to its root in ST_FIND, points the nodes on that path at the root
// in ST_COMP, then waits in ST_DONE; a union does both walks plus ST_MERGE; a flagged item goes straight to ST_DONE.
// One item at a time: a result waiting in ST_DONE for the output register holds the next
// item off.
// Reset (synchronous, aresetn low) and each element_count write clear all valid bits at once.
`default_nettype none

module disjoint_set_union_find
    import dsu_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Request items
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [7:0] elem_a, [15:8] elem_b
    input  wire logic [0:0]           s_tuser,   // [0] action (0 find, 1 union)
    // Result items
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // [7:0] root_of_a, [16:8] set_count, zeros above
    output logic [M_TUSER_W-1:0]      m_tuser,   // [0] merged, [1] index_error
    // element_count write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [COUNT_W-1:0]   cfg_data
);

    count_t   elem_count_reg;
    count_t   eff_count;
    logic     in_accept;
    logic     cfg_wr;
    logic     walk_idle;
    mem_req_t mem_req;
    elem_t    rd_parent;
    logic     res_valid;
    dsu_res_t res;
    count_t   merge_total;
    logic     out_free;

    logic     m_tvalid_reg;
    dsu_res_t m_res_reg;

    // Take items and register writes only while the sequencer is idle and out of reset;
    // a pending register write goes first, so an item never starts beside it.
    assign s_tready  = walk_idle && aresetn && !cfg_valid;
    assign cfg_ready = walk_idle && aresetn;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // Saturate the element count at the table depth.
    assign eff_count = (elem_count_reg > COUNT_RESET) ? COUNT_RESET : elem_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elem_count_reg <= COUNT_RESET;
        end else if (cfg_wr) begin
            elem_count_reg <= cfg_data;
        end
    end

    dsu_parent_mem u_mem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (cfg_wr),
        .req       (mem_req),
        .rd_parent (rd_parent)
    );

    dsu_walker u_walker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .in_action   (s_tuser[0]),
        .in_a        (s_tdata[7:0]),
        .in_b        (s_tdata[15:8]),
        .count       (eff_count),
        .cfg_wr      (cfg_wr),
        .rd_parent   (rd_parent),
        .out_free    (out_free),
        .idle        (walk_idle),
        .mem_req     (mem_req),
        .res_valid   (res_valid),
        .res         (res),
        .merge_total (merge_total)
    );

    // Output register: hold a finished item until taken, so the next request can start.
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - ELEM_W - COUNT_W){1'b0}},
                       m_res_reg.set_count, m_res_reg.root};
    assign m_tuser  = {m_res_reg.index_error, m_res_reg.merged};

`include "disjoint_set_union_find_assert.svh"

    // A flagged item neither merges nor reports a root.
    `DSU_ASSERT_IMP(a_err_clean, aclk, aresetn, m_tvalid && m_tuser[1], !m_tuser[0] && (m_tdata[7:0] == 8'd0))
    // Accepting an item makes the engine busy on the next cycle.
    `DSU_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, in_accept, !s_tready && !cfg_ready)
    // A register write restarts the merge count.
    `DSU_ASSERT_NEXT(a_cfg_clears, aclk, aresetn, cfg_wr, merge_total == '0)

endmodule

`default_nettype wire

@@ sv/dsu_parent_mem.sv @@
// Parent table: one-read one-write memory, registered read, write-to-read forwarding.
// Per-entry valid bits make an unwritten entry read as its own index. Uses dsu_pkg.
`default_nettype none

module dsu_parent_mem
    import dsu_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     clear,
    input  wire mem_req_t req,
    output elem_t         rd_parent
);

    elem_t                    mem_reg [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0]  valid_reg;
    elem_t                    rd_data_reg;
    elem_t                    rd_addr_reg;
    logic                     rd_valid_reg;
    logic                     fwd_reg;
    elem_t                    fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_reg[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg  <= mem_reg[req.rd_addr];
        rd_addr_reg  <= req.rd_addr;
        rd_valid_reg <= valid_reg[req.rd_addr];
        fwd_reg      <= req.wr_en && (req.wr_addr == req.rd_addr);
        fwd_data_reg <= req.wr_data;
    end

    // Valid bits: drop all at reset or reinitialisation, set on write.
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    assign rd_parent = fwd_reg      ? fwd_data_reg :
                       rd_valid_reg ? rd_data_reg  : rd_addr_reg;

endmodule

`default_nettype wire

@@ sv/dsu_walker.sv @@
// Sequencer for find and union: walks parent links, compresses paths, merges roots.
// Drives the parent table through mem_req_t. Uses dsu_pkg.
`default_nettype none

module dsu_walker
    import dsu_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   in_accept,
    input  wire logic   in_action,
    input  wire elem_t  in_a,
    input  wire elem_t  in_b,
    input  wire count_t count,
    input  wire logic   cfg_wr,
    input  wire elem_t  rd_parent,
    input  wire logic   out_free,
    output logic        idle,
    output mem_req_t    mem_req,
    output logic        res_valid,
    output dsu_res_t    res,
    output count_t      merge_total
);

    walk_state_t state_reg, state_next;
    logic   action_reg, action_next;
    logic   phase_reg, phase_next;
    elem_t  b_reg, b_next;
    elem_t  cur_reg, cur_next;
    elem_t  start_reg, start_next;
    elem_t  root_reg, root_next;
    elem_t  root_a_reg, root_a_next;
    elem_t  root_b_reg, root_b_next;
    logic   merged_reg, merged_next;
    logic   err_reg, err_next;
    count_t merge_total_reg, merge_total_next;

    logic   fin;
    elem_t  fin_root;
    logic   in_err;

    assign in_err = ({1'b0, in_a} >= count) ||
                    ((in_action == ACT_UNION) && ({1'b0, in_b} >= count));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            merge_total_reg <= '0;
        end else begin
            state_reg       <= state_next;
            merge_total_reg <= merge_total_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg <= action_next;
        phase_reg  <= phase_next;
        b_reg      <= b_next;
        cur_reg    <= cur_next;
        start_reg  <= start_next;
        root_reg   <= root_next;
        root_a_reg <= root_a_next;
        root_b_reg <= root_b_next;
        merged_reg <= merged_next;
        err_reg    <= err_next;
    end

    always_comb begin
        state_next       = state_reg;
        action_next      = action_reg;
        phase_next       = phase_reg;
        b_next           = b_reg;
        cur_next         = cur_reg;
        start_next       = start_reg;
        root_next        = root_reg;
        root_a_next      = root_a_reg;
        root_b_next      = root_b_reg;
        merged_next      = merged_reg;
        err_next         = err_reg;
        merge_total_next = merge_total_reg;
        mem_req          = '{rd_addr: cur_reg, wr_en: 1'b0, wr_addr: cur_reg,
                             wr_data: root_reg};
        res_valid        = 1'b0;
        fin              = 1'b0;
        fin_root         = root_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    action_next     = in_action;
                    b_next          = in_b;
                    cur_next        = in_a;
                    start_next      = in_a;
                    phase_next      = 1'b0;
                    merged_next     = 1'b0;
                    err_next        = in_err;
                    root_a_next     = '0;
                    mem_req.rd_addr = in_a;
                    state_next      = in_err ? ST_DONE : ST_FIND;
                end
            end
            ST_FIND: begin
                if (rd_parent == cur_reg) begin
                    root_next = cur_reg;
                    if (start_reg == cur_reg) begin
                        fin      = 1'b1;
                        fin_root = cur_reg;
                    end else begin
                        cur_next        = start_reg;
                        mem_req.rd_addr = start_reg;
                        state_next      = ST_COMP;
                    end
                end else begin
                    cur_next        = rd_parent;
                    mem_req.rd_addr = rd_parent;
                end
            end
            ST_COMP: begin
                // Point the current node at the root, advance along the old link.
                mem_req.wr_en = 1'b1;
                if (rd_parent == root_reg) begin
                    fin      = 1'b1;
                    fin_root = root_reg;
                end else begin
                    cur_next        = rd_parent;
                    mem_req.rd_addr = rd_parent;
                end
            end
            ST_MERGE: begin
                if (root_a_reg != root_b_reg) begin
                    mem_req.wr_en    = 1'b1;
                    mem_req.wr_addr  = root_b_reg;
                    mem_req.wr_data  = root_a_reg;
                    merge_total_next = merge_total_reg + count_t'(1);
                    merged_next      = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // End of one walk: start the second element of a union, or finish.
        if (fin) begin
            if (!phase_reg) begin
                root_a_next = fin_root;
                if (action_reg == ACT_UNION) begin
                    phase_next      = 1'b1;
                    cur_next        = b_reg;
                    start_next      = b_reg;
                    mem_req.rd_addr = b_reg;
                    state_next      = ST_FIND;
                end else begin
                    state_next = ST_DONE;
                end
            end else begin
                root_b_next = fin_root;
                state_next  = ST_MERGE;
            end
        end

        if (cfg_wr) begin
            merge_total_next = '0;
        end
    end

    assign idle        = (state_reg == ST_IDLE);
    assign merge_total = merge_total_reg;

    always_comb begin
        res.root        = root_a_reg;
        res.merged      = merged_reg;
        res.index_error = err_reg;
        res.set_count   = (count >= merge_total_reg) ? (count - merge_total_reg) : '0;
    end

endmodule

`default_nettype wire
